[rtl/fsp_pkg.sv]
// Shared types, constants and helpers for the FASTA stream parser.
// No dependencies; used by fsp_ctrl, fsp_datapath and fasta_stream_parser.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    // Width of the running sequence length counter
    localparam int LEN_BITS       = 32;
    // Longest run of carriage returns that may be held back
    localparam int MAX_PENDING_CR = 7;
    localparam int PEND_W         = $clog2(MAX_PENDING_CR + 1);

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;

    typedef enum logic [2:0] {
        PH_PRE    = 3'd0,
        PH_HDR    = 3'd1,
        PH_SEQ_LS = 3'd2,
        PH_SEQ    = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ID_WAIT = 2'd0,
        ID_IN   = 2'd1,
        ID_PAST = 2'd2
    } t_id_phase;

    typedef enum logic [2:0] {
        K_HDR = 3'd0,
        K_SEQ = 3'd1,
        K_END = 3'd2,
        K_ERR = 3'd3,
        K_FIN = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_FORMAT  = 2'd0,
        ERR_SEQ_OVF = 2'd1,
        ERR_CR_RUN  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FIN   = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic   emit;
        t_kind  kind;
        t_err   err;
        logic   last;
        logic   sel_cr;
        logic   latch;
        logic   start_hdr;
        logic   set_phase;
        t_phase phase;
        logic   pend_inc;
        logic   pend_dec;
        logic   pend_clr;
        logic   len_inc;
        logic   len_clr;
        logic   set_failed;
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_phase phase;
        logic   failed;
        logic   eoi;
        logic   is_gt;
        logic   is_nl;
        logic   is_cr;
        logic   pend_zero;
        logic   pend_full;
        logic   len_full;
        logic   out_free;
    } t_dp_stat;

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

[rtl/fasta_stream_parser.sv]
// FASTA stream parser: byte stream in, header/sequence/record results out.
// Top level; depends on fsp_pkg, fsp_ctrl and fsp_datapath.
//
// Input channel: one beat per file byte (i_in_byte), or an end-of-input mark
// (i_end_of_input = 1). Output channel: one beat per result, with o_kind,
// o_out_byte, o_in_id, o_seq_length, o_error_code, and o_last on the final
// beat caused by an input beat. Input beats that cause no result (newline,
// held carriage return, dropped bytes) produce no output beat.
// Every result is registered in the output register. Throughput: one input
// beat per cycle when each causes at most one result and the receiver does
// not stall. An end of input inside a record gives two results (record
// end, then finish). A byte that follows held carriage returns is first
// captured, then each held carriage return is released, then the byte,
// all through the single output register.
// After reset the parser waits for the first header line; no clearing pass.
// When the receiver stalls, the result waits in the output register and
// o_in_ready drops until it is taken; nothing is lost. After an error every
// later input beat is taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module fasta_stream_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_input,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_in_id,
    output logic [31:0]      o_seq_length,
    output logic [1:0]       o_error_code,
    output logic             o_last
);

    fsp_pkg::t_ctl_cmd cmd;
    fsp_pkg::t_dp_stat stat;
    logic              use_latched;

    // Sequence each item
    fsp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_use_latched (use_latched)
    );

    // Hold parse state and the output beat
    fsp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_use_latched  (use_latched),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_in_id        (o_in_id),
        .o_seq_length   (o_seq_length),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[rtl/fsp_datapath.sv]
// Parser datapath: record state, held carriage-return count, length counter
// and the output register. Depends on fsp_pkg; driven by fsp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fsp_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fsp_pkg::t_ctl_cmd i_cmd,
    input  wire logic              i_use_latched,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_end_of_input,
    input  wire logic              i_out_ready,
    output fsp_pkg::t_dp_stat      o_stat,
    output logic                   o_out_valid,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_in_id,
    output logic [31:0]            o_seq_length,
    output logic [1:0]             o_error_code,
    output logic                   o_last
);

    // Record state
    fsp_pkg::t_phase                r_phase, n_phase;
    fsp_pkg::t_id_phase             r_id, n_id;
    logic [fsp_pkg::PEND_W-1:0]     r_pend, n_pend;
    logic [fsp_pkg::LEN_BITS-1:0]   r_len, n_len;
    logic                           r_failed, n_failed;
    logic [7:0]                     r_byte;

    // Output register
    logic                           r_ovalid;
    fsp_pkg::t_kind                 r_kind;
    logic [7:0]                     r_obyte;
    logic                           r_inid;
    logic [31:0]                    r_olen;
    fsp_pkg::t_err                  r_err;
    logic                           r_last;

    logic [7:0]                     cur_byte;
    logic [7:0]                     emit_byte;
    logic                           emit_ws;
    logic                           emit_inid;
    logic [31:0]                    len_out;
    logic                           out_free;

    assign cur_byte  = i_use_latched ? r_byte : i_in_byte;
    assign emit_byte = i_cmd.sel_cr ? fsp_pkg::CH_CR : cur_byte;
    assign emit_ws   = fsp_pkg::is_ws(emit_byte);
    assign len_out   = 32'(r_len);
    assign out_free  = !r_ovalid || i_out_ready;

    // Report status
    always_comb begin
        o_stat.phase     = r_phase;
        o_stat.failed    = r_failed;
        o_stat.eoi       = i_end_of_input;
        o_stat.is_gt     = (cur_byte == fsp_pkg::CH_GT);
        o_stat.is_nl     = (cur_byte == fsp_pkg::CH_NL);
        o_stat.is_cr     = (cur_byte == fsp_pkg::CH_CR);
        o_stat.pend_zero = (r_pend == '0);
        o_stat.pend_full = (r_pend >= fsp_pkg::PEND_W'(fsp_pkg::MAX_PENDING_CR));
        o_stat.len_full  = &r_len;
        o_stat.out_free  = out_free;
    end

    // Track the id token across header bytes
    always_comb begin
        n_id      = r_id;
        emit_inid = 1'b0;
        if (i_cmd.start_hdr) begin
            n_id = fsp_pkg::ID_WAIT;
        end else if (i_cmd.emit && (i_cmd.kind == fsp_pkg::K_HDR)) begin
            unique case (r_id)
                fsp_pkg::ID_WAIT: begin
                    if (!emit_ws) begin
                        n_id      = fsp_pkg::ID_IN;
                        emit_inid = 1'b1;
                    end
                end
                fsp_pkg::ID_IN: begin
                    if (emit_ws) begin
                        n_id = fsp_pkg::ID_PAST;
                    end else begin
                        emit_inid = 1'b1;
                    end
                end
                default: begin
                    n_id = r_id;
                end
            endcase
        end
    end

    // Advance phase, held count, length and error flag
    always_comb begin
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_len    = r_len;
        n_failed = r_failed || i_cmd.set_failed;
        if (i_cmd.start_hdr) begin
            n_phase = fsp_pkg::PH_HDR;
            n_pend  = '0;
            n_len   = '0;
        end else begin
            if (i_cmd.set_phase) begin
                n_phase = i_cmd.phase;
            end
            if (i_cmd.pend_clr) begin
                n_pend = '0;
            end else if (i_cmd.pend_inc) begin
                n_pend = r_pend + {{(fsp_pkg::PEND_W-1){1'b0}}, 1'b1};
            end else if (i_cmd.pend_dec) begin
                n_pend = r_pend - {{(fsp_pkg::PEND_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.len_clr) begin
                n_len = '0;
            end else if (i_cmd.len_inc) begin
                n_len = r_len + {{(fsp_pkg::LEN_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= fsp_pkg::PH_PRE;
            r_id     <= fsp_pkg::ID_WAIT;
            r_pend   <= '0;
            r_len    <= '0;
            r_failed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_id     <= n_id;
            r_pend   <= n_pend;
            r_len    <= n_len;
            r_failed <= n_failed;
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Hold the byte of an item whose results span several beats
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_in_byte;
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind  <= i_cmd.kind;
            r_last  <= i_cmd.last;
            r_inid  <= emit_inid;
            r_obyte <= ((i_cmd.kind == fsp_pkg::K_HDR) || (i_cmd.kind == fsp_pkg::K_SEQ))
                       ? emit_byte : 8'h00;
            r_olen  <= (i_cmd.kind == fsp_pkg::K_END) ? len_out : 32'h0;
            r_err   <= (i_cmd.kind == fsp_pkg::K_ERR) ? i_cmd.err : fsp_pkg::ERR_FORMAT;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_obyte;
    assign o_in_id      = r_inid;
    assign o_seq_length = r_olen;
    assign o_error_code = r_err;
    assign o_last       = r_last;

    // A beat is never loaded over one that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("beat loaded while output register held");

    // Held carriage returns never pass the bound
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= fsp_pkg::PEND_W'(fsp_pkg::MAX_PENDING_CR))
        else $error("held carriage-return count over bound");

    // Id marks appear on header bytes only
    a_inid_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_inid) |-> (r_kind == fsp_pkg::K_HDR))
        else $error("id mark on a non-header beat");

    // An error stays until reset
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("error flag cleared without reset");

endmodule

`default_nettype wire

[rtl/fsp_ctrl.sv]
// Parser controller: decides the results of each input item and sequences
// multi-beat items. Depends on fsp_pkg; commands fsp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module fsp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fsp_pkg::t_dp_stat i_stat,
    output fsp_pkg::t_ctl_cmd      o_cmd,
    output logic                   o_use_latched
);

    fsp_pkg::t_state r_state, n_state;
    logic            in_fire;
    logic            in_rec;
    logic            hdr;
    logic            plain;

    // Command for one header or sequence byte, or a length overflow
    function automatic fsp_pkg::t_ctl_cmd char_cmd(
        input fsp_pkg::t_ctl_cmd base,
        input logic              is_hdr,
        input logic              len_full,
        input logic              is_last,
        input logic              is_cr
    );
        fsp_pkg::t_ctl_cmd c;
        c        = base;
        c.emit   = 1'b1;
        c.sel_cr = is_cr;
        if (is_hdr) begin
            c.kind     = fsp_pkg::K_HDR;
            c.last     = is_last;
            c.pend_dec = is_cr;
        end else if (len_full) begin
            c.kind       = fsp_pkg::K_ERR;
            c.err        = fsp_pkg::ERR_SEQ_OVF;
            c.last       = 1'b1;
            c.set_failed = 1'b1;
            c.pend_clr   = 1'b1;
        end else begin
            c.kind      = fsp_pkg::K_SEQ;
            c.last      = is_last;
            c.len_inc   = 1'b1;
            c.pend_dec  = is_cr;
            c.set_phase = 1'b1;
            c.phase     = fsp_pkg::PH_SEQ;
        end
        return c;
    endfunction

    assign o_in_ready    = (r_state == fsp_pkg::ST_IDLE) && i_stat.out_free;
    assign o_use_latched = (r_state != fsp_pkg::ST_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign in_rec        = (i_stat.phase == fsp_pkg::PH_HDR)
                        || (i_stat.phase == fsp_pkg::PH_SEQ_LS)
                        || (i_stat.phase == fsp_pkg::PH_SEQ);
    assign hdr           = (i_stat.phase == fsp_pkg::PH_HDR);
    // Ordinary byte inside a record (no newline, CR, or new header)
    assign plain         = in_rec && !i_stat.is_nl && !i_stat.is_cr
                        && !((i_stat.phase == fsp_pkg::PH_SEQ_LS) && i_stat.is_gt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsp_pkg::ST_IDLE: begin
                if (in_fire && !i_stat.failed) begin
                    if (i_stat.eoi) begin
                        if (in_rec) begin
                            n_state = fsp_pkg::ST_FIN;
                        end
                    end else if (plain && !i_stat.pend_zero) begin
                        n_state = fsp_pkg::ST_FLUSH;
                    end
                end
            end
            fsp_pkg::ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = fsp_pkg::ST_IDLE;
                end
            end
            fsp_pkg::ST_FLUSH: begin
                if (i_stat.out_free && (i_stat.pend_zero || (!hdr && i_stat.len_full))) begin
                    n_state = fsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fsp_pkg::ST_IDLE: begin
                if (in_fire && !i_stat.failed) begin
                    if (i_stat.eoi) begin
                        if (in_rec) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = fsp_pkg::K_END;
                        end else begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.kind      = fsp_pkg::K_FIN;
                            o_cmd.last      = 1'b1;
                            o_cmd.set_phase = 1'b1;
                            o_cmd.phase     = fsp_pkg::PH_DONE;
                            o_cmd.pend_clr  = 1'b1;
                            o_cmd.len_clr   = 1'b1;
                        end
                    end else if (i_stat.phase == fsp_pkg::PH_PRE) begin
                        if (i_stat.is_gt) begin
                            o_cmd.start_hdr = 1'b1;
                        end else if (!i_stat.is_nl) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.kind       = fsp_pkg::K_ERR;
                            o_cmd.err        = fsp_pkg::ERR_FORMAT;
                            o_cmd.last       = 1'b1;
                            o_cmd.set_failed = 1'b1;
                        end
                    end else if ((i_stat.phase == fsp_pkg::PH_SEQ_LS) && i_stat.is_gt) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.kind      = fsp_pkg::K_END;
                        o_cmd.last      = 1'b1;
                        o_cmd.start_hdr = 1'b1;
                    end else if (in_rec) begin
                        if (i_stat.is_nl) begin
                            o_cmd.pend_clr  = 1'b1;
                            o_cmd.len_clr   = hdr;
                            o_cmd.set_phase = 1'b1;
                            o_cmd.phase     = fsp_pkg::PH_SEQ_LS;
                        end else if (i_stat.is_cr) begin
                            if (i_stat.pend_full) begin
                                o_cmd.emit       = 1'b1;
                                o_cmd.kind       = fsp_pkg::K_ERR;
                                o_cmd.err        = fsp_pkg::ERR_CR_RUN;
                                o_cmd.last       = 1'b1;
                                o_cmd.set_failed = 1'b1;
                            end else begin
                                o_cmd.pend_inc  = 1'b1;
                                o_cmd.set_phase = !hdr;
                                o_cmd.phase     = fsp_pkg::PH_SEQ;
                            end
                        end else if (!i_stat.pend_zero) begin
                            o_cmd.latch = 1'b1;
                        end else begin
                            o_cmd = char_cmd(o_cmd, hdr, i_stat.len_full, 1'b1, 1'b0);
                        end
                    end
                end
            end
            fsp_pkg::ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = fsp_pkg::K_FIN;
                    o_cmd.last      = 1'b1;
                    o_cmd.set_phase = 1'b1;
                    o_cmd.phase     = fsp_pkg::PH_DONE;
                    o_cmd.pend_clr  = 1'b1;
                    o_cmd.len_clr   = 1'b1;
                end
            end
            fsp_pkg::ST_FLUSH: begin
                if (i_stat.out_free) begin
                    if (!i_stat.pend_zero) begin
                        o_cmd = char_cmd(o_cmd, hdr, i_stat.len_full, 1'b0, 1'b1);
                    end else begin
                        o_cmd = char_cmd(o_cmd, hdr, i_stat.len_full, 1'b1, 1'b0);
                    end
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/tb_fasta_stream_parser.sv]
// Self-checking testbench for fasta_stream_parser: directed table, then random FASTA records.
// Depends on fsp_pkg for port types and constants; predicts result beats in-line, apart from typed directed rows.
`timescale 1ns / 1ps

module tb_fasta_stream_parser;
    import fsp_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] BASES [5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};
    localparam int RANDOM_BEATS = 450;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        TAIL_CUT_HEADER,
        TAIL_END_IN_SEQ,
        TAIL_CR_OVERRUN
    } t_tail;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        in_id;
        logic [31:0] len;
        t_err        err;
        logic        last;
    } t_result;

    // One directed beat; typed rows carry their expectation (at most one result)
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       has_res;
        t_kind      kind;
        logic [7:0] rdata;
        logic       rid;
        t_err       err;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_in_byte      = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic        o_in_id;
    logic [31:0] o_seq_length;
    logic [1:0]  o_error_code;
    logic        o_last;

    fasta_stream_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_in_id        (o_in_id),
        .o_seq_length   (o_seq_length),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Parser state as the predictor tracks it
    t_phase              ps_phase   = PH_PRE;
    t_id_phase           ps_id      = ID_WAIT;
    int                  ps_cr_held = 0;
    logic [LEN_BITS-1:0] ps_seq_len = '0;
    bit                  ps_halted  = 1'b0;

    t_result   beat_results[$];
    t_result   results_due[$];
    t_stim_row dir_rows[$];
    int        fail_cnt    = 0;
    int        idle_cycles = 0;
    int        beats_sent  = 0;
    int        cr_run      = 0;
    int        rx_hold     = 0;
    bit        rx_calm     = 1'b0;
    bit        tx_calm     = 1'b0;

    function automatic bit blank_char(logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

    function automatic void add_result(t_kind k, logic [7:0] d, logic id, logic [31:0] len,
                                       t_err e);
        t_result r;
        r.kind  = k;
        r.data  = d;
        r.in_id = id;
        r.len   = len;
        r.err   = e;
        r.last  = 1'b0;
        beat_results.push_back(r);
    endfunction

    // Emit one header byte and advance the id token tracking
    function automatic void header_out(logic [7:0] c);
        logic id;
        id = 1'b0;
        if (ps_id == ID_WAIT) begin
            if (!blank_char(c)) begin
                ps_id = ID_IN;
                id    = 1'b1;
            end
        end else if (ps_id == ID_IN) begin
            if (blank_char(c)) ps_id = ID_PAST;
            else id = 1'b1;
        end
        add_result(K_HDR, c, id, 32'd0, ERR_FORMAT);
    endfunction

    // Emit one sequence byte; flag overflow instead when the length is saturated
    function automatic bit sequence_out(logic [7:0] c);
        if (ps_seq_len == {LEN_BITS{1'b1}}) begin
            ps_halted = 1'b1;
            add_result(K_ERR, 8'h00, 1'b0, 32'd0, ERR_SEQ_OVF);
            return 1'b0;
        end
        ps_seq_len = ps_seq_len + 1'b1;
        add_result(K_SEQ, c, 1'b0, 32'd0, ERR_FORMAT);
        return 1'b1;
    endfunction

    function automatic void open_header();
        ps_phase   = PH_HDR;
        ps_id      = ID_WAIT;
        ps_cr_held = 0;
        ps_seq_len = '0;
    endfunction

    // Predict the result beats caused by one accepted input beat
    function automatic void parse_beat(logic [7:0] c, logic eoi);
        bit      in_hdr;
        bit      ok;
        bit      in_record;
        t_result tail_res;
        beat_results.delete();
        if (ps_halted) return;
        in_record = (ps_phase == PH_HDR) || (ps_phase == PH_SEQ_LS) || (ps_phase == PH_SEQ);
        if (eoi) begin
            if (in_record) add_result(K_END, 8'h00, 1'b0, 32'(ps_seq_len), ERR_FORMAT);
            add_result(K_FIN, 8'h00, 1'b0, 32'd0, ERR_FORMAT);
            ps_phase   = PH_DONE;
            ps_cr_held = 0;
            ps_seq_len = '0;
        end else if (ps_phase == PH_PRE) begin
            if (c == CH_GT) begin
                open_header();
            end else if (c != CH_NL) begin
                ps_halted = 1'b1;
                add_result(K_ERR, 8'h00, 1'b0, 32'd0, ERR_FORMAT);
            end
        end else if (ps_phase == PH_SEQ_LS && c == CH_GT) begin
            add_result(K_END, 8'h00, 1'b0, 32'(ps_seq_len), ERR_FORMAT);
            open_header();
        end else if (in_record) begin
            in_hdr = (ps_phase == PH_HDR);
            if (c == CH_NL) begin
                ps_cr_held = 0;
                if (in_hdr) ps_seq_len = '0;
                ps_phase = PH_SEQ_LS;
            end else if (c == CH_CR) begin
                if (ps_cr_held >= MAX_PENDING_CR) begin
                    ps_halted = 1'b1;
                    add_result(K_ERR, 8'h00, 1'b0, 32'd0, ERR_CR_RUN);
                end else begin
                    ps_cr_held++;
                    if (!in_hdr) ps_phase = PH_SEQ;
                end
            end else begin
                // Release held carriage returns ahead of the byte
                ok = 1'b1;
                while (ps_cr_held > 0 && ok) begin
                    ps_cr_held--;
                    if (in_hdr) header_out(CH_CR);
                    else ok = sequence_out(CH_CR);
                end
                if (ok) begin
                    if (in_hdr) begin
                        header_out(c);
                    end else begin
                        ok       = sequence_out(c);
                        ps_phase = PH_SEQ;
                    end
                end
                if (!ok) ps_cr_held = 0;
            end
        end
        if (beat_results.size() > 0) begin
            tail_res      = beat_results.pop_back();
            tail_res.last = 1'b1;
            beat_results.push_back(tail_res);
        end
    endfunction

    // Stall length: mostly short, a few long
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] header_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(33, 126));
        if (r < 55) return CH_SP;
        if (r < 62) return CH_HT;
        if (r < 67) return CH_VT;
        if (r < 72) return CH_FF;
        if (r < 80) return CH_CR;
        return any_byte();
    endfunction

    function automatic logic [7:0] sequence_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return BASES[$urandom_range(0, 4)];
        if (r < 70) return 8'($urandom_range(33, 126));
        if (r < 82) return any_byte();
        if (r < 94) return CH_CR;
        return CH_GT;
    endfunction

    function automatic t_stim_row checked(logic [7:0] d);
        t_stim_row r;
        r      = '0;
        r.data = d;
        return r;
    endfunction

    function automatic t_stim_row quiet(logic [7:0] d);
        t_stim_row r;
        r       = '0;
        r.data  = d;
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row gives(logic [7:0] d, t_kind k, logic [7:0] rd, logic id);
        t_stim_row r;
        r         = '0;
        r.data    = d;
        r.typed   = 1'b1;
        r.has_res = 1'b1;
        r.kind    = k;
        r.rdata   = rd;
        r.rid     = id;
        r.err     = ERR_FORMAT;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    // Drive one input beat after a random gap, hold it until accepted, then predict
    task automatic send_beat(input logic [7:0] d, input logic eoi);
        int gap;
        gap = (tx_calm || $urandom_range(0, 9) < 6) ? 0 : stall_len();
        i_in_valid = 1'b0;
        repeat (gap) @(negedge i_clk);
        i_in_byte      = d;
        i_end_of_input = eoi;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_beat(d, eoi);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic feed(input logic [7:0] d, input logic eoi);
        send_beat(d, eoi);
        foreach (beat_results[k]) results_due.push_back(beat_results[k]);
    endtask

    // Feed a text byte, capping carriage-return runs so the run never trips the bound
    task automatic put_text(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (v == CH_CR && cr_run >= MAX_PENDING_CR) v = BASES[4];
        cr_run = (v == CH_CR) ? cr_run + 1 : 0;
        feed(v, 1'b0);
        beats_sent++;
    endtask

    task automatic drain();
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    // One well-formed record with random content
    task automatic gen_record();
        int hlen;
        int nlines;
        int llen;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        put_text(CH_GT);
        hlen = $urandom_range(0, 12);
        repeat (hlen) put_text(header_char());
        put_text(CH_NL);
        nlines = $urandom_range(0, 3);
        repeat (nlines) begin
            llen = $urandom_range(0, 25);
            repeat (llen) put_text(sequence_char());
            put_text(CH_NL);
        end
    endtask

    // Stall the result channel at random
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready = 1'b0;
            rx_hold--;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            i_out_ready = 1'b0;
            rx_hold     = stall_len() - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // Check each result beat against the oldest expectation; watch for a hang
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: kind %0d, byte %0h", o_kind, o_out_byte);
                    fail_cnt++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(o_kind));
                    check_field("out_byte", 32'(want.data), 32'(o_out_byte));
                    check_field("in_id", 32'(want.in_id), 32'(o_in_id));
                    check_field("seq_length", want.len, o_seq_length);
                    check_field("error_code", 32'(want.err), 32'(o_error_code));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row row;
        t_tail     tail;
        bit        paused;

        // Directed rows: preamble, id tracking, held carriage returns, extremes
        dir_rows.push_back(quiet(CH_NL));
        dir_rows.push_back(quiet(CH_NL));
        dir_rows.push_back(quiet(CH_GT));
        dir_rows.push_back(gives(CH_SP, K_HDR, CH_SP, 1'b0));
        dir_rows.push_back(gives(8'h41, K_HDR, 8'h41, 1'b1));
        dir_rows.push_back(quiet(CH_CR));
        dir_rows.push_back(quiet(CH_CR));
        dir_rows.push_back(checked(8'h62));
        dir_rows.push_back(gives(8'hFF, K_HDR, 8'hFF, 1'b0));
        dir_rows.push_back(gives(8'h00, K_HDR, 8'h00, 1'b0));
        dir_rows.push_back(quiet(CH_CR));
        dir_rows.push_back(quiet(CH_NL));
        dir_rows.push_back(quiet(CH_NL));
        dir_rows.push_back(gives(8'h41, K_SEQ, 8'h41, 1'b0));
        repeat (MAX_PENDING_CR) dir_rows.push_back(quiet(CH_CR));
        dir_rows.push_back(checked(8'h47));
        dir_rows.push_back(quiet(CH_NL));
        dir_rows.push_back(checked(CH_GT));
        dir_rows.push_back(gives(CH_VT, K_HDR, CH_VT, 1'b0));
        dir_rows.push_back(gives(CH_GT, K_HDR, CH_GT, 1'b1));
        dir_rows.push_back(quiet(CH_NL));

        // Hold reset, release on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_beat(row.data, 1'b0);
            if (row.typed) begin
                if (row.has_res) begin
                    results_due.push_back(t_result'{kind: row.kind, data: row.rdata,
                        in_id: row.rid, len: 32'd0, err: row.err, last: 1'b1});
                end
            end else begin
                foreach (beat_results[j]) results_due.push_back(beat_results[j]);
            end
        end
        drain();

        // Random records; pause once mid-way until every result is out
        paused = 1'b0;
        while (beats_sent < RANDOM_BEATS) begin
            gen_record();
            if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        // Finish the file one of three ways, then poke the stopped parser
        tail = t_tail'($urandom_range(0, 2));
        case (tail)
            TAIL_CUT_HEADER: begin
                put_text(CH_GT);
                put_text(8'h68);
                put_text(CH_SP);
                feed(any_byte(), 1'b1);
            end
            TAIL_END_IN_SEQ: begin
                put_text(BASES[0]);
                put_text(CH_CR);
                put_text(CH_CR);
                feed(any_byte(), 1'b1);
            end
            default: begin
                repeat (MAX_PENDING_CR + 1) feed(CH_CR, 1'b0);
            end
        endcase
        repeat (3) feed(any_byte(), 1'b0);
        feed(any_byte(), 1'b1);

        // Wait out the last results, then check that none are still due
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/fsp_pkg.sv
rtl/fsp_datapath.sv
rtl/fsp_ctrl.sv
rtl/fasta_stream_parser.sv
tb/tb_fasta_stream_parser.sv
